@@ hdl/aeas_pkg.sv @@
// Shared widths, types, network coefficients and helper functions of the anomaly scorer.
package aeas_pkg;

    // Fixed-point formats.
    localparam int FRAC_BITS   = 16;
    localparam int WEIGHT_FRAC = 14;
    localparam int NUM_IN      = 4;
    localparam int NUM_HID     = 2;

    // Port widths.
    localparam int RAW_W   = 9;
    localparam int OXY_W   = 7;
    localparam int SCORE_W = 23;

    // Normalizer widths. A reading that reaches the span saturates, so the
    // offset that is divided always fits in SPAN_W bits.
    localparam int SPAN_W    = 7;
    localparam int NUMER_W   = FRAC_BITS + SPAN_W;
    localparam int DIV_SHIFT = NUMER_W;
    localparam int RECIP_W   = FRAC_BITS + 3;
    localparam int QPROD_W   = NUMER_W + RECIP_W;

    // Datapath widths.
    localparam int NUM_W      = FRAC_BITS + 1;
    localparam int ACT_W      = FRAC_BITS + 2;
    localparam int COEF_W     = 16;
    localparam int ENC_PROD_W = NUM_W + 1 + COEF_W;
    localparam int DEC_PROD_W = ACT_W + 1 + COEF_W;
    localparam int ACC_W      = FRAC_BITS + 20;
    localparam int ERR_W      = FRAC_BITS + 3;
    localparam int MAG_W      = FRAC_BITS + 2;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int SCALED_W   = SUM_W + 5;
    localparam int SHIFTED_W  = SCALED_W - FRAC_BITS;
    localparam int SAT_W      = (SHIFTED_W > SCORE_W) ? SHIFTED_W : SCORE_W;

    typedef logic [RAW_W-1:0]          raw_t;
    typedef logic [NUM_W-1:0]          num_t;
    typedef logic [ACT_W-1:0]          act_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic [SCORE_W-1:0]        score_t;
    typedef raw_t [NUM_IN-1:0]         raw_vec_t;
    typedef num_t [NUM_IN-1:0]         num_vec_t;
    typedef act_t [NUM_HID-1:0]        hid_vec_t;
    typedef act_t [NUM_IN-1:0]         out_vec_t;

    localparam num_t   NUM_ONE    = {1'b1, {FRAC_BITS{1'b0}}};
    localparam acc_t   ROUND_HALF = acc_t'(1) <<< (WEIGHT_FRAC - 1);
    localparam score_t SCORE_MAX  = '1;

    // Normalization limits: systolic, diastolic, heart rate, SpO2.
    localparam raw_t NORM_LO [NUM_IN] = '{9'd80, 9'd50, 9'd40, 9'd80};
    localparam logic [SPAN_W-1:0] NORM_SPAN [NUM_IN] = '{7'd100, 7'd70, 7'd100, 7'd20};
    localparam logic [SPAN_W-1:0] NORM_HALF [NUM_IN] = '{
        SPAN_W'(100 / 2), SPAN_W'(70 / 2), SPAN_W'(100 / 2), SPAN_W'(20 / 2)};

    // Truncated reciprocals of the spans; the quotient they give is low by
    // at most one and is corrected after a remainder check.
    localparam logic [RECIP_W-1:0] NORM_RECIP [NUM_IN] = '{
        RECIP_W'((64'd1 << DIV_SHIFT) / 100),
        RECIP_W'((64'd1 << DIV_SHIFT) / 70),
        RECIP_W'((64'd1 << DIV_SHIFT) / 100),
        RECIP_W'((64'd1 << DIV_SHIFT) / 20)};

    // Network coefficients in signed Q2.14.
    localparam coef_t ENC_W [NUM_HID][NUM_IN] = '{
        '{16'sd8192, 16'sd7373, 16'sd4915, -16'sd1638},
        '{-16'sd3277, -16'sd2458, 16'sd1638, 16'sd13107}};
    localparam coef_t ENC_B [NUM_HID] = '{16'sd1638, 16'sd1638};
    localparam coef_t DEC_W [NUM_IN][NUM_HID] = '{
        '{16'sd8192, -16'sd3277},
        '{16'sd7373, -16'sd2458},
        '{16'sd4915, 16'sd1638},
        '{-16'sd1638, 16'sd13107}};
    localparam coef_t DEC_B [NUM_IN] = '{16'sd819, 16'sd819, 16'sd819, 16'sd1638};

    // Bias aligned to the accumulator's fraction.
    function automatic acc_t bias_term(input coef_t b);
        acc_t ext;
        ext = acc_t'(b);
        return ext <<< FRAC_BITS;
    endfunction

    // ReLU, then round the accumulator back to the activation fraction.
    function automatic act_t relu_round(input acc_t acc);
        acc_t rnd;
        act_t res;
        rnd = acc + ROUND_HALF;
        if (acc <= 0)
        begin
            res = '0;
        end
        else
        begin
            res = rnd[WEIGHT_FRAC +: ACT_W];
        end
        return res;
    endfunction

endpackage

@@ hdl/aeas_norm.sv @@
// Three-stage min-max normalizer for the four readings.
module aeas_norm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  aeas_pkg::raw_vec_t raw,
    output logic              out_valid,
    output aeas_pkg::num_vec_t norm
);
    import aeas_pkg::*;

    logic [2:0] valid_reg;

    // Stage one: offset, range flags and the scaled numerator.
    logic [NUMER_W-1:0] numer_next [NUM_IN];
    logic               zero_next  [NUM_IN];
    logic               sat_next   [NUM_IN];
    logic [NUMER_W-1:0] numer1_reg [NUM_IN];
    logic               zero1_reg  [NUM_IN];
    logic               sat1_reg   [NUM_IN];

    // Stage two: quotient estimate from the reciprocal.
    num_t               quot_next  [NUM_IN];
    num_t               quot2_reg  [NUM_IN];
    logic [NUMER_W-1:0] numer2_reg [NUM_IN];
    logic               zero2_reg  [NUM_IN];
    logic               sat2_reg   [NUM_IN];

    // Stage three: remainder correction and clamping.
    num_t norm_next [NUM_IN];
    num_t norm_reg  [NUM_IN];

    always_comb
    begin
        logic signed [RAW_W:0] diff;
        for (int k = 0; k < NUM_IN; k++)
        begin
            diff = $signed({1'b0, raw[k]}) - $signed({1'b0, NORM_LO[k]});
            zero_next[k]  = (diff <= 0);
            sat_next[k]   = (diff >= $signed({{(RAW_W + 1 - SPAN_W){1'b0}}, NORM_SPAN[k]}));
            numer_next[k] = {diff[SPAN_W-1:0], {FRAC_BITS{1'b0}}}
                            + NUMER_W'(NORM_HALF[k]);
        end
    end

    always_comb
    begin
        logic [QPROD_W-1:0] qprod;
        for (int k = 0; k < NUM_IN; k++)
        begin
            qprod        = QPROD_W'(numer1_reg[k]) * QPROD_W'(NORM_RECIP[k]);
            quot_next[k] = qprod[DIV_SHIFT +: NUM_W];
        end
    end

    always_comb
    begin
        logic [NUMER_W:0] back;
        logic [NUMER_W:0] rem;
        logic             fix;
        for (int k = 0; k < NUM_IN; k++)
        begin
            back = (NUMER_W + 1)'(quot2_reg[k]) * (NUMER_W + 1)'(NORM_SPAN[k]);
            rem  = {1'b0, numer2_reg[k]} - back;
            fix  = (rem >= (NUMER_W + 1)'(NORM_SPAN[k]));
            if (zero2_reg[k])
            begin
                norm_next[k] = '0;
            end
            else if (sat2_reg[k])
            begin
                norm_next[k] = NUM_ONE;
            end
            else
            begin
                norm_next[k] = quot2_reg[k] + num_t'(fix);
            end
        end
    end

    // Valid bits follow the words down the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_IN; k++)
        begin
            numer1_reg[k] <= numer_next[k];
            zero1_reg[k]  <= zero_next[k];
            sat1_reg[k]   <= sat_next[k];
            quot2_reg[k]  <= quot_next[k];
            numer2_reg[k] <= numer1_reg[k];
            zero2_reg[k]  <= zero1_reg[k];
            sat2_reg[k]   <= sat1_reg[k];
            norm_reg[k]   <= norm_next[k];
        end
    end

    assign out_valid = valid_reg[2];

    always_comb
    begin
        for (int k = 0; k < NUM_IN; k++)
        begin
            norm[k] = norm_reg[k];
        end
    end

endmodule

@@ hdl/aeas_encoder.sv @@
// Two-stage encoder layer: products, then sum with bias and ReLU.
module aeas_encoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  aeas_pkg::num_vec_t norm_in,
    output logic               out_valid,
    output aeas_pkg::hid_vec_t hid,
    output aeas_pkg::num_vec_t norm_out
);
    import aeas_pkg::*;

    logic [1:0] valid_reg;
    logic signed [ENC_PROD_W-1:0] prod_reg [NUM_HID][NUM_IN];
    num_vec_t norm1_reg;
    num_vec_t norm2_reg;
    hid_vec_t hid_next;
    hid_vec_t hid_reg;

    // Weighted sum and activation of each hidden unit.
    always_comb
    begin
        acc_t acc;
        for (int i = 0; i < NUM_HID; i++)
        begin
            acc = bias_term(ENC_B[i]);
            for (int j = 0; j < NUM_IN; j++)
            begin
                acc = acc + acc_t'(prod_reg[i][j]);
            end
            hid_next[i] = relu_round(acc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    // One multiplier per weight, registered before the adder tree.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_HID; i++)
        begin
            for (int j = 0; j < NUM_IN; j++)
            begin
                prod_reg[i][j] <= $signed({1'b0, norm_in[j]}) * ENC_W[i][j];
            end
        end
        norm1_reg <= norm_in;
        norm2_reg <= norm1_reg;
        hid_reg   <= hid_next;
    end

    assign out_valid = valid_reg[1];
    assign hid       = hid_reg;
    assign norm_out  = norm2_reg;

endmodule

@@ hdl/aeas_decoder.sv @@
// Two-stage decoder layer: products, then sum with bias and ReLU.
module aeas_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  aeas_pkg::hid_vec_t hid,
    input  aeas_pkg::num_vec_t norm_in,
    output logic               out_valid,
    output aeas_pkg::out_vec_t recon,
    output aeas_pkg::num_vec_t norm_out
);
    import aeas_pkg::*;

    logic [1:0] valid_reg;
    logic signed [DEC_PROD_W-1:0] prod_reg [NUM_IN][NUM_HID];
    num_vec_t norm1_reg;
    num_vec_t norm2_reg;
    out_vec_t recon_next;
    out_vec_t recon_reg;

    // Reconstruction of each input from the two hidden units.
    always_comb
    begin
        acc_t acc;
        for (int i = 0; i < NUM_IN; i++)
        begin
            acc = bias_term(DEC_B[i]);
            for (int j = 0; j < NUM_HID; j++)
            begin
                acc = acc + acc_t'(prod_reg[i][j]);
            end
            recon_next[i] = relu_round(acc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_IN; i++)
        begin
            for (int j = 0; j < NUM_HID; j++)
            begin
                prod_reg[i][j] <= $signed({1'b0, hid[j]}) * DEC_W[i][j];
            end
        end
        norm1_reg <= norm_in;
        norm2_reg <= norm1_reg;
        recon_reg <= recon_next;
    end

    assign out_valid = valid_reg[1];
    assign recon     = recon_reg;
    assign norm_out  = norm2_reg;

endmodule

@@ hdl/aeas_score.sv @@
// Four-stage error unit: absolute error, squares, sum, scaled and saturated score.
module aeas_score (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  aeas_pkg::num_vec_t norm,
    input  aeas_pkg::out_vec_t recon,
    output logic               out_valid,
    output aeas_pkg::score_t   score
);
    import aeas_pkg::*;

    logic [3:0] valid_reg;
    logic [MAG_W-1:0]    mag_next [NUM_IN];
    logic [MAG_W-1:0]    mag_reg  [NUM_IN];
    logic [SQ_W-1:0]     sq_reg   [NUM_IN];
    logic [SUM_W-1:0]    sum_next;
    logic [SUM_W-1:0]    sum_reg;
    score_t              score_next;
    score_t              score_reg;

    // Magnitude of the reconstruction error.
    always_comb
    begin
        logic signed [ERR_W-1:0] err;
        logic signed [ERR_W-1:0] abs_err;
        for (int k = 0; k < NUM_IN; k++)
        begin
            err         = $signed({2'b00, norm[k]}) - $signed({1'b0, recon[k]});
            abs_err     = (err < 0) ? -err : err;
            mag_next[k] = abs_err[MAG_W-1:0];
        end
    end

    // Sum of the four squares.
    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < NUM_IN; k++)
        begin
            sum_next = sum_next + SUM_W'(sq_reg[k]);
        end
    end

    // Times 25 with rounding, drop the fraction, then saturate.
    always_comb
    begin
        logic [SCALED_W-1:0]  ext;
        logic [SCALED_W-1:0]  scaled;
        logic [SHIFTED_W-1:0] shifted;
        logic [SAT_W-1:0]     wide;
        ext     = SCALED_W'(sum_reg);
        scaled  = (ext << 4) + (ext << 3) + ext + (SCALED_W'(1) << (FRAC_BITS - 1));
        shifted = scaled[FRAC_BITS +: SHIFTED_W];
        wide    = SAT_W'(shifted);
        if (wide > SAT_W'(SCORE_MAX))
        begin
            score_next = SCORE_MAX;
        end
        else
        begin
            score_next = wide[SCORE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_IN; k++)
        begin
            mag_reg[k] <= mag_next[k];
            sq_reg[k]  <= SQ_W'(mag_reg[k]) * SQ_W'(mag_reg[k]);
        end
        sum_reg   <= sum_next;
        score_reg <= score_next;
    end

    assign out_valid = valid_reg[3];
    assign score     = score_reg;

endmodule

@@ hdl/autoencoder_anomaly_score.sv @@
// Top level of the 4-2-4 autoencoder anomaly scorer for vital-sign readings.
//
//   Channel  | Handshake     | Word
//   ---------+---------------+------------------------------------------------------
//   reading  | start / busy  | systolic, diastolic, heart_rate, oxygen_saturation
//   score    | done (strobe) | anomaly_score
//
// A word is taken at every clock edge where start is high; busy stays low.
// Each word passes through the normalizer (offset, reciprocal multiply,
// remainder fix), the encoder and decoder layers, and the error unit.
// One word enters and one score leaves per cycle at most.
// Reset clears only the valid bits of the pipeline; data registers keep
// whatever they hold. The score receiver cannot stall, so nothing waits.
module autoencoder_anomaly_score (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  aeas_pkg::raw_t                    systolic,
    input  aeas_pkg::raw_t                    diastolic,
    input  aeas_pkg::raw_t                    heart_rate,
    input  logic [aeas_pkg::OXY_W-1:0]        oxygen_saturation,
    output logic                              done,
    output aeas_pkg::score_t                  anomaly_score
);
    import aeas_pkg::*;

    logic     accept;
    raw_vec_t raw;
    logic     norm_valid;
    num_vec_t norm;
    logic     enc_valid;
    hid_vec_t hid;
    num_vec_t norm_enc;
    logic     dec_valid;
    out_vec_t recon;
    num_vec_t norm_dec;

    // The pipeline never holds off a word.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Gather the readings in channel order.
    assign raw[0] = systolic;
    assign raw[1] = diastolic;
    assign raw[2] = heart_rate;
    assign raw[3] = RAW_W'(oxygen_saturation);

    aeas_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .raw       (raw),
        .out_valid (norm_valid),
        .norm      (norm)
    );

    aeas_encoder u_encoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (norm_valid),
        .norm_in   (norm),
        .out_valid (enc_valid),
        .hid       (hid),
        .norm_out  (norm_enc)
    );

    aeas_decoder u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (enc_valid),
        .hid       (hid),
        .norm_in   (norm_enc),
        .out_valid (dec_valid),
        .recon     (recon),
        .norm_out  (norm_dec)
    );

    aeas_score u_score (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .norm      (norm_dec),
        .recon     (recon),
        .out_valid (done),
        .score     (anomaly_score)
    );

endmodule

@@ test/tb_autoencoder_anomaly_score.sv @@
// Self-checking testbench for the vital-sign autoencoder anomaly scorer.
`timescale 1ns / 100ps

module tb_autoencoder_anomaly_score;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYC   = 11;
    localparam int DRAIN_CYC   = 24;
    localparam int RANDOM_WORDS = 750;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    // Normalization limits of the four readings.
    localparam int SYS_LO  = 80;
    localparam int SYS_SPAN = 100;
    localparam int DIA_LO  = 50;
    localparam int DIA_SPAN = 70;
    localparam int HR_LO   = 40;
    localparam int HR_SPAN  = 100;
    localparam int OXY_LO  = 80;
    localparam int OXY_SPAN = 20;
    localparam int RAW_TOP = 511;
    localparam int OXY_TOP = 127;

    // Score tracker: predicts the score of every accepted word and checks
    // the scores that come back, in order.
    class score_tracker;
        aeas_pkg::score_t pending_scores[$];
        int mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Min-max normalize one reading to Q1.16, rounding half up.
        function longint norm_reading(longint raw, longint lo, longint span);
            longint offs;
            longint q;
            offs = raw - lo;
            if (offs <= 0)
            begin
                return 0;
            end
            q = (offs * 65536 + span / 2) / span;
            return (q > 65536) ? 65536 : q;
        endfunction

        // ReLU, then drop the 14 coefficient fraction bits with rounding.
        function longint relu_q(longint acc);
            if (acc <= 0)
            begin
                return 0;
            end
            return (acc + 8192) >>> 14;
        endfunction

        function aeas_pkg::score_t predict_score(longint sys, longint dia, longint hr,
                                                 longint oxy);
            longint n0, n1, n2, n3;
            longint h0, h1;
            longint r0, r1, r2, r3;
            longint e0, e1, e2, e3;
            longint unsigned sq_sum;
            longint unsigned sc;
            n0 = norm_reading(sys, SYS_LO, SYS_SPAN);
            n1 = norm_reading(dia, DIA_LO, DIA_SPAN);
            n2 = norm_reading(hr, HR_LO, HR_SPAN);
            n3 = norm_reading(oxy, OXY_LO, OXY_SPAN);
            // Encoder: two hidden units.
            h0 = relu_q(64'sd1638 * 65536 + 8192 * n0 + 7373 * n1 + 4915 * n2 - 1638 * n3);
            h1 = relu_q(64'sd1638 * 65536 - 3277 * n0 - 2458 * n1 + 1638 * n2 + 13107 * n3);
            // Decoder: reconstruction of the four normalized readings.
            r0 = relu_q(64'sd819 * 65536 + 8192 * h0 - 3277 * h1);
            r1 = relu_q(64'sd819 * 65536 + 7373 * h0 - 2458 * h1);
            r2 = relu_q(64'sd819 * 65536 + 4915 * h0 + 1638 * h1);
            r3 = relu_q(64'sd1638 * 65536 - 1638 * h0 + 13107 * h1);
            e0 = n0 - r0;
            e1 = n1 - r1;
            e2 = n2 - r2;
            e3 = n3 - r3;
            sq_sum = e0 * e0 + e1 * e1 + e2 * e2 + e3 * e3;
            // Mean times one hundred is the sum times 25, back to 16 fraction bits.
            sc = (sq_sum * 25 + 32768) >> 16;
            if (sc > 64'd8388607)
            begin
                sc = 64'd8388607;
            end
            return aeas_pkg::score_t'(sc);
        endfunction

        function void note_reading(aeas_pkg::raw_t sys, aeas_pkg::raw_t dia,
                                   aeas_pkg::raw_t hr, logic [aeas_pkg::OXY_W-1:0] oxy);
            pending_scores.push_back(predict_score(sys, dia, hr, oxy));
        endfunction

        function void check_score(aeas_pkg::score_t got);
            aeas_pkg::score_t want;
            if (pending_scores.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("unexpected score word: got %0d", got);
                end
                return;
            end
            want = pending_scores.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("anomaly_score mismatch: expected %0d, got %0d", want, got);
                end
            end
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    aeas_pkg::raw_t               systolic;
    aeas_pkg::raw_t               diastolic;
    aeas_pkg::raw_t               heart_rate;
    logic [aeas_pkg::OXY_W-1:0]   oxygen_saturation;
    logic                         done;
    aeas_pkg::score_t             anomaly_score;

    score_tracker tracker;
    int           cycle_count;
    bit           steady_run;

    autoencoder_anomaly_score uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .systolic          (systolic),
        .diastolic         (diastolic),
        .heart_rate        (heart_rate),
        .oxygen_saturation (oxygen_saturation),
        .done              (done),
        .anomaly_score     (anomaly_score)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Every score word is checked at the edge that ends its strobe cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            tracker.check_score(anomaly_score);
        end
    end

    // Present one word and hold it until the block takes it.
    task automatic send_word(input int sys, input int dia, input int hr, input int oxy);
        @(negedge clk);
        start             <= 1'b1;
        systolic          <= aeas_pkg::raw_t'(sys);
        diastolic         <= aeas_pkg::raw_t'(dia);
        heart_rate        <= aeas_pkg::raw_t'(hr);
        oxygen_saturation <= aeas_pkg::OXY_W'(oxy);
        do
        begin
            @(posedge clk);
        end
        while (busy);
        tracker.note_reading(systolic, diastolic, heart_rate, oxygen_saturation);
    endtask

    // Idle cycles with start low; the fields carry noise meanwhile.
    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start             <= 1'b0;
            systolic          <= aeas_pkg::raw_t'($urandom);
            diastolic         <= aeas_pkg::raw_t'($urandom);
            heart_rate        <= aeas_pkg::raw_t'($urandom);
            oxygen_saturation <= aeas_pkg::OXY_W'($urandom);
        end
    endtask

    // Gap length: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady_run || r < 50)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_then_gap(input int sys, input int dia, input int hr, input int oxy);
        send_word(sys, dia, hr, oxy);
        idle_cycles(gap_len());
    endtask

    // Random reading: mostly near the normalization range, some anywhere,
    // some right on its corners.
    function automatic int pick_reading(input int lo, input int span, input int top);
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return $urandom_range(lo - 5, lo + span + 5);
        end
        if (r < 85)
        begin
            return $urandom_range(0, top);
        end
        case ($urandom_range(0, 7))
            0: return 0;
            1: return lo - 1;
            2: return lo;
            3: return lo + 1;
            4: return lo + span - 1;
            5: return lo + span;
            6: return lo + span + 1;
            default: return top;
        endcase
    endfunction

    initial
    begin
        tracker           = new();
        steady_run        = 1'b0;
        rst_n             = 1'b0;
        start             = 1'b0;
        systolic          = '0;
        diastolic         = '0;
        heart_rate        = '0;
        oxygen_saturation = '0;
        repeat (RESET_CYC) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        idle_cycles(2);

        // Directed words: field extremes, limits and their neighbors,
        // and inputs that drive hidden and output units into ReLU cutoff.
        send_then_gap(0, 0, 0, 0);
        send_then_gap(RAW_TOP, RAW_TOP, RAW_TOP, OXY_TOP);
        send_then_gap(SYS_LO, DIA_LO, HR_LO, OXY_LO);
        send_then_gap(SYS_LO + 1, DIA_LO + 1, HR_LO + 1, OXY_LO + 1);
        send_then_gap(SYS_LO - 1, DIA_LO - 1, HR_LO - 1, OXY_LO - 1);
        send_then_gap(SYS_LO + SYS_SPAN, DIA_LO + DIA_SPAN, HR_LO + HR_SPAN, OXY_LO + OXY_SPAN);
        send_then_gap(SYS_LO + SYS_SPAN - 1, DIA_LO + DIA_SPAN - 1, HR_LO + HR_SPAN - 1,
                      OXY_LO + OXY_SPAN - 1);
        send_then_gap(SYS_LO + SYS_SPAN + 1, DIA_LO + DIA_SPAN + 1, HR_LO + HR_SPAN + 1,
                      OXY_LO + OXY_SPAN + 1);
        send_then_gap(120, 80, 70, 97);
        send_then_gap(0, 0, 0, OXY_TOP);
        send_then_gap(RAW_TOP, RAW_TOP, 0, 0);
        send_then_gap(RAW_TOP, 0, 0, 0);
        send_then_gap(0, RAW_TOP, 0, 0);
        send_then_gap(0, 0, RAW_TOP, 0);
        send_then_gap(9'h155, 9'h0AA, 9'h155, 7'h2A);
        send_then_gap(9'h0AA, 9'h155, 9'h0AA, 7'h55);
        send_then_gap(RAW_TOP, RAW_TOP, RAW_TOP, 0);
        send_then_gap(0, 0, 0, OXY_LO + OXY_SPAN);
        send_then_gap(SYS_LO + SYS_SPAN / 2, DIA_LO + DIA_SPAN / 2, HR_LO + HR_SPAN / 2,
                      OXY_LO + OXY_SPAN / 2);

        // Random words, with stretches of back-to-back traffic.
        for (int k = 0; k < RANDOM_WORDS; k++)
        begin
            if (k % 40 == 0)
            begin
                steady_run = ($urandom_range(0, 3) == 0);
            end
            send_then_gap(pick_reading(SYS_LO, SYS_SPAN, RAW_TOP),
                          pick_reading(DIA_LO, DIA_SPAN, RAW_TOP),
                          pick_reading(HR_LO, HR_SPAN, RAW_TOP),
                          pick_reading(OXY_LO, OXY_SPAN, OXY_TOP));
        end
        idle_cycles(1);

        // Drain: wait for every predicted score, then watch for strays.
        while (tracker.pending_scores.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYC) @(posedge clk);
        if (tracker.mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/aeas_pkg.sv
hdl/aeas_norm.sv
hdl/aeas_encoder.sv
hdl/aeas_decoder.sv
hdl/aeas_score.sv
hdl/autoencoder_anomaly_score.sv
test/tb_autoencoder_anomaly_score.sv
